// ----- src/block_schur_matrix_inverse_defines.svh -----
// Assertion macros used by the controller RTL file (bsmi_ctrl.sv) of the block.
`ifndef BLOCK_SCHUR_MATRIX_INVERSE_DEFINES_SVH
`define BLOCK_SCHUR_MATRIX_INVERSE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSMI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bsmi: assertion failed");
`define BSMI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bsmi: assertion failed");
`else
`define BSMI_ASSERT(lbl, clk, rstn, prop)
`define BSMI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/bsmi_pkg.sv -----
package bsmi_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_MAC  = 3'd0;
    localparam op_t OP_MSB  = 3'd1;
    localparam op_t OP_ADD  = 3'd2;
    localparam op_t OP_SUB  = 3'd3;
    localparam op_t OP_NEG  = 3'd4;
    localparam op_t OP_CPY  = 3'd5;
    localparam op_t OP_DIV  = 3'd6;
    localparam op_t OP_DIVN = 3'd7;

    localparam logic [1:0] MK_INV = 2'd0;
    localparam logic [1:0] MK_MM  = 2'd1;
    localparam logic [1:0] MK_EW  = 2'd2;

    localparam logic [5:0] Y_BASE = 6'd48;

    // First and last program entries for each matrix order
    localparam logic [3:0] PC_SMALL = 4'd0;
    localparam logic [3:0] PC_BIG   = 4'd1;
    localparam logic [3:0] PC_END_BIG = 4'd15;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [5:0]  addr_a;
        logic [5:0]  addr_b;
        logic [5:0]  addr_d;
        logic        first;
        logic        last;
        logic        load_en;
        logic        load_first;
        logic [3:0]  load_addr;
        logic        out_rd;
        logic [3:0]  out_addr;
        logic        gate_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_sts_t;

    typedef struct packed {
        logic [1:0] kind;
        op_t        ew_op;
        logic [5:0] a_base;
        logic       a_sl;
        logic [5:0] b_base;
        logic       b_sl;
        logic [5:0] d_base;
        logic       d_sl;
    } macro_t;

    function automatic macro_t mk(input logic [1:0] kind, input op_t ew_op,
                                  input logic [5:0] ab, input logic asl,
                                  input logic [5:0] bb, input logic bsl,
                                  input logic [5:0] db, input logic dsl);
        macro_t m;
        m.kind   = kind;
        m.ew_op  = ew_op;
        m.a_base = ab;
        m.a_sl   = asl;
        m.b_base = bb;
        m.b_sl   = bsl;
        m.d_base = db;
        m.d_sl   = dsl;
        return m;
    endfunction

    // Block program. Input blocks: a11 0, a12 2, a21 8, a22 10 (row stride 4).
    // Temporaries (row stride 2): ia 16, sb 20, ib 24, t1 28, t2 32.
    // Result at 48 (row stride 4 for order 4, 2 for order 2).
    function automatic macro_t bsmi_macro(input logic [3:0] pc);
        macro_t m;
        unique case (pc)
            4'd0:  m = mk(MK_INV, OP_MAC, 6'd0,  1'b0, 6'd0,  1'b0, 6'd48, 1'b0);
            4'd1:  m = mk(MK_INV, OP_MAC, 6'd0,  1'b1, 6'd0,  1'b1, 6'd16, 1'b0);
            4'd2:  m = mk(MK_MM,  OP_MAC, 6'd8,  1'b1, 6'd16, 1'b0, 6'd28, 1'b0);
            4'd3:  m = mk(MK_MM,  OP_MAC, 6'd28, 1'b0, 6'd2,  1'b1, 6'd32, 1'b0);
            4'd4:  m = mk(MK_EW,  OP_SUB, 6'd10, 1'b1, 6'd32, 1'b0, 6'd20, 1'b0);
            4'd5:  m = mk(MK_INV, OP_MAC, 6'd20, 1'b0, 6'd20, 1'b0, 6'd24, 1'b0);
            4'd6:  m = mk(MK_MM,  OP_MAC, 6'd16, 1'b0, 6'd2,  1'b1, 6'd28, 1'b0);
            4'd7:  m = mk(MK_MM,  OP_MAC, 6'd28, 1'b0, 6'd24, 1'b0, 6'd32, 1'b0);
            4'd8:  m = mk(MK_EW,  OP_NEG, 6'd32, 1'b0, 6'd32, 1'b0, 6'd50, 1'b1);
            4'd9:  m = mk(MK_MM,  OP_MAC, 6'd32, 1'b0, 6'd8,  1'b1, 6'd28, 1'b0);
            4'd10: m = mk(MK_MM,  OP_MAC, 6'd28, 1'b0, 6'd16, 1'b0, 6'd32, 1'b0);
            4'd11: m = mk(MK_EW,  OP_ADD, 6'd16, 1'b0, 6'd32, 1'b0, 6'd48, 1'b1);
            4'd12: m = mk(MK_MM,  OP_MAC, 6'd24, 1'b0, 6'd8,  1'b1, 6'd28, 1'b0);
            4'd13: m = mk(MK_MM,  OP_MAC, 6'd28, 1'b0, 6'd16, 1'b0, 6'd32, 1'b0);
            4'd14: m = mk(MK_EW,  OP_NEG, 6'd32, 1'b0, 6'd32, 1'b0, 6'd56, 1'b1);
            default: m = mk(MK_EW, OP_CPY, 6'd24, 1'b0, 6'd24, 1'b0, 6'd58, 1'b1);
        endcase
        return m;
    endfunction

endpackage

// ----- src/bsmi_datapath.sv -----
module bsmi_datapath
    import bsmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] load_value,
    output dp_sts_t            sts,
    output logic signed [31:0] result_value
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_EX   = 3'd1;
    localparam logic [2:0] P_WB   = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_DFIN = 3'd4;

    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    logic signed [31:0] mem [64];
    logic signed [31:0] rd_a_reg, rd_b_reg;

    logic [2:0]         phase_reg, phase_next;
    logic               done_reg, done_next;
    logic               nz_reg, nz_next;
    op_t                op_reg, op_next;
    logic [5:0]         addr_d_reg, addr_d_next;
    logic               first_reg, first_next, last_reg, last_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] det_reg, det_next;
    logic [63:0]        dvd_reg, dvd_next;
    logic [64:0]        rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic [63:0]        ud_reg, ud_next;
    logic               neg_reg, neg_next;
    logic [5:0]         dcnt_reg, dcnt_next;

    logic               wb_en;
    logic signed [31:0] wb_data;
    logic               we;
    logic [5:0]         waddr;
    logic signed [31:0] wdata;
    logic               rd_en_a;
    logic [5:0]         raddr_a;

    logic signed [63:0] q_rnd, acc_sum, ew_a, ew_b, ew_r;
    logic signed [32:0] x_val;
    logic [31:0]        x_abs;
    logic [63:0]        det_abs;
    logic [64:0]        rem_s;
    logic               q_big;

    assign rd_en_a = cmd.start | cmd.out_rd;
    assign raddr_a = cmd.start ? cmd.addr_a : (Y_BASE + {2'b00, cmd.out_addr});

    assign we    = cmd.load_en | wb_en;
    assign waddr = cmd.load_en ? {2'b00, cmd.load_addr} : addr_d_reg;
    assign wdata = cmd.load_en ? load_value : wb_data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en_a) begin
            rd_a_reg <= mem[raddr_a];
        end
        if (cmd.start) begin
            rd_b_reg <= mem[cmd.addr_b];
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        done_next   = 1'b0;
        nz_next     = nz_reg;
        op_next     = op_reg;
        addr_d_next = addr_d_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        det_next    = det_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        ud_next     = ud_reg;
        neg_next    = neg_reg;
        dcnt_next   = dcnt_reg;
        wb_en       = 1'b0;
        wb_data     = '0;

        q_rnd   = (prod_reg + HALF_LSB) >>> FRAC_BITS;
        acc_sum = (first_reg ? 64'sd0 : acc_reg) + ((op_reg == OP_MSB) ? -q_rnd : q_rnd);
        ew_a    = 64'(rd_a_reg);
        ew_b    = 64'(rd_b_reg);
        x_val   = (op_reg == OP_DIVN) ? -33'(rd_a_reg) : 33'(rd_a_reg);
        x_abs   = x_val[32] ? 32'(-x_val) : x_val[31:0];
        det_abs = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
        rem_s   = {rem_reg[63:0], dvd_reg[63]};
        q_big   = |quo_reg[63:31];

        unique case (op_reg)
            OP_ADD:  ew_r = ew_a + ew_b;
            OP_SUB:  ew_r = ew_a - ew_b;
            OP_NEG:  ew_r = -ew_a;
            default: ew_r = ew_a;
        endcase

        if (cmd.load_en) begin
            nz_next = (cmd.load_first ? 1'b0 : nz_reg) | (load_value != 32'sd0);
        end

        unique case (phase_reg)
            P_IDLE: begin
                if (cmd.start) begin
                    op_next     = cmd.op;
                    addr_d_next = cmd.addr_d;
                    first_next  = cmd.first;
                    last_next   = cmd.last;
                    phase_next  = P_EX;
                end
            end
            P_EX: begin
                if (op_reg == OP_MAC || op_reg == OP_MSB) begin
                    prod_next  = rd_a_reg * rd_b_reg;
                    phase_next = P_WB;
                end else if (op_reg == OP_DIV || op_reg == OP_DIVN) begin
                    if (det_reg == 64'sd0) begin
                        // singular block: the whole inverse is zero
                        wb_en      = 1'b1;
                        wb_data    = '0;
                        done_next  = 1'b1;
                        phase_next = P_IDLE;
                    end else begin
                        ud_next    = det_abs;
                        neg_next   = x_val[32] ^ det_reg[63];
                        dvd_next   = (64'(x_abs) << FRAC_BITS) + (det_abs >> 1);
                        rem_next   = '0;
                        quo_next   = '0;
                        dcnt_next  = '0;
                        phase_next = P_DIV;
                    end
                end else begin
                    wb_en      = 1'b1;
                    wb_data    = sat32(ew_r);
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
            end
            P_WB: begin
                acc_next = acc_sum;
                if (last_reg) begin
                    if (op_reg == OP_MSB) begin
                        det_next = acc_sum;
                    end else begin
                        wb_en   = 1'b1;
                        wb_data = sat32(acc_sum);
                    end
                end
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            P_DIV: begin
                if (rem_s >= {1'b0, ud_reg}) begin
                    rem_next = rem_s - {1'b0, ud_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_s;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                dvd_next  = {dvd_reg[62:0], 1'b0};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63) begin
                    phase_next = P_DFIN;
                end
            end
            P_DFIN: begin
                wb_en = 1'b1;
                if (neg_reg) begin
                    wb_data = q_big ? 32'sh8000_0000 : -$signed(quo_reg[31:0]);
                end else begin
                    wb_data = q_big ? 32'sh7FFF_FFFF : $signed(quo_reg[31:0]);
                end
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            nz_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            nz_reg    <= nz_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        addr_d_reg <= addr_d_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        det_reg    <= det_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ud_reg     <= ud_next;
        neg_reg    <= neg_next;
        dcnt_reg   <= dcnt_next;
    end

    assign sts.done     = done_reg;
    assign result_value = (cmd.gate_zero && !nz_reg) ? 32'sd0 : rd_a_reg;

endmodule

// ----- src/bsmi_ctrl.sv -----
`include "block_schur_matrix_inverse_defines.svh"

module bsmi_ctrl
    import bsmi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_tlast,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_SHOW  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] order_reg, order_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] pc_reg, pc_next;
    logic [2:0] uc_reg, uc_next;

    macro_t     m;
    logic       is4, cnt_last, uc_last;
    logic [2:0] uc_len_m1;
    logic [3:0] pc_end;

    function automatic logic [5:0] blk_addr(input logic [5:0] base, input logic sl,
                                            input logic i, input logic j);
        return base + (sl ? {3'b000, i, 2'b00} : {4'b0000, i, 1'b0}) + {5'b00000, j};
    endfunction

    assign is4      = order_reg[1];
    assign cnt_last = (cnt_reg == (is4 ? 4'd15 : 4'd3));
    assign pc_end   = is4 ? PC_END_BIG : PC_SMALL;
    assign m        = bsmi_macro(pc_reg);

    always_comb begin
        unique case (m.kind)
            MK_MM:   uc_len_m1 = 3'd7;
            MK_EW:   uc_len_m1 = 3'd3;
            default: uc_len_m1 = 3'd5;
        endcase
    end
    assign uc_last = (uc_reg == uc_len_m1);

    // Decode one arithmetic step of the current block operation and select the next state
    always_comb begin
        cmd           = '0;
        cmd.gate_zero = is4;
        cmd.load_addr = cnt_reg;
        cmd.out_addr  = cnt_reg;
        cmd.first     = 1'b1;
        cmd.last      = 1'b1;
        unique case (m.kind)
            MK_MM: begin
                cmd.op     = OP_MAC;
                cmd.addr_a = blk_addr(m.a_base, m.a_sl, uc_reg[2], uc_reg[0]);
                cmd.addr_b = blk_addr(m.b_base, m.b_sl, uc_reg[0], uc_reg[1]);
                cmd.addr_d = blk_addr(m.d_base, m.d_sl, uc_reg[2], uc_reg[1]);
                cmd.first  = !uc_reg[0];
                cmd.last   = uc_reg[0];
            end
            MK_EW: begin
                cmd.op     = m.ew_op;
                cmd.addr_a = blk_addr(m.a_base, m.a_sl, uc_reg[1], uc_reg[0]);
                cmd.addr_b = blk_addr(m.b_base, m.b_sl, uc_reg[1], uc_reg[0]);
                cmd.addr_d = blk_addr(m.d_base, m.d_sl, uc_reg[1], uc_reg[0]);
            end
            default: begin
                cmd.addr_b = blk_addr(m.a_base, m.a_sl, 1'b0, 1'b0);
                unique case (uc_reg)
                    3'd0: begin
                        cmd.op     = OP_MAC;
                        cmd.addr_a = blk_addr(m.a_base, m.a_sl, 1'b0, 1'b0);
                        cmd.addr_b = blk_addr(m.a_base, m.a_sl, 1'b1, 1'b1);
                        cmd.last   = 1'b0;
                    end
                    3'd1: begin
                        cmd.op     = OP_MSB;
                        cmd.addr_a = blk_addr(m.a_base, m.a_sl, 1'b0, 1'b1);
                        cmd.addr_b = blk_addr(m.a_base, m.a_sl, 1'b1, 1'b0);
                        cmd.first  = 1'b0;
                    end
                    3'd2: begin
                        cmd.op     = OP_DIV;
                        cmd.addr_a = blk_addr(m.a_base, m.a_sl, 1'b1, 1'b1);
                        cmd.addr_d = blk_addr(m.d_base, m.d_sl, 1'b0, 1'b0);
                    end
                    3'd3: begin
                        cmd.op     = OP_DIV;
                        cmd.addr_a = blk_addr(m.a_base, m.a_sl, 1'b0, 1'b0);
                        cmd.addr_d = blk_addr(m.d_base, m.d_sl, 1'b1, 1'b1);
                    end
                    3'd4: begin
                        cmd.op     = OP_DIVN;
                        cmd.addr_a = blk_addr(m.a_base, m.a_sl, 1'b0, 1'b1);
                        cmd.addr_d = blk_addr(m.d_base, m.d_sl, 1'b0, 1'b1);
                    end
                    default: begin
                        cmd.op     = OP_DIVN;
                        cmd.addr_a = blk_addr(m.a_base, m.a_sl, 1'b1, 1'b0);
                        cmd.addr_d = blk_addr(m.d_base, m.d_sl, 1'b1, 1'b0);
                    end
                endcase
            end
        endcase

        state_next = state_reg;
        order_next = order_reg;
        cnt_next   = cnt_reg;
        pc_next    = pc_reg;
        uc_next    = uc_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (s_tvalid && !cfg_valid) begin
                    cmd.load_en    = 1'b1;
                    cmd.load_first = (cnt_reg == 4'd0);
                    if (cnt_last) begin
                        cnt_next   = '0;
                        pc_next    = is4 ? PC_BIG : PC_SMALL;
                        uc_next    = '0;
                        state_next = S_ISSUE;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                if (cfg_valid) begin
                    order_next = cfg_data;
                    cnt_next   = '0;
                end
            end
            S_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (sts.done) begin
                    if (!uc_last) begin
                        uc_next    = uc_reg + 3'd1;
                        state_next = S_ISSUE;
                    end else if (pc_reg == pc_end) begin
                        cnt_next   = '0;
                        state_next = S_FETCH;
                    end else begin
                        pc_next    = pc_reg + 4'd1;
                        uc_next    = '0;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FETCH: begin
                cmd.out_rd = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW: begin
                if (m_tready) begin
                    if (cnt_last) begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end else begin
                        cnt_next   = cnt_reg + 4'd1;
                        state_next = S_FETCH;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            order_reg <= 2'd2;
            cnt_reg   <= '0;
            pc_reg    <= '0;
            uc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            order_reg <= order_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            uc_reg    <= uc_next;
        end
    end

    // A register write takes precedence over an element in the same cycle
    assign cfg_ready = (state_reg == S_LOAD);
    assign s_tready  = (state_reg == S_LOAD) && !cfg_valid;
    assign m_tvalid  = (state_reg == S_SHOW);
    assign m_tlast   = cnt_last;

    `BSMI_ASSERT(a_no_load_while_show, aclk, aresetn, !(s_tready && m_tvalid))
    `BSMI_ASSERT(a_done_only_waiting, aclk, aresetn, (sts.done |-> (state_reg == S_WAIT)))
    `BSMI_ASSERT(a_last_reopens_input, aclk, aresetn, ((m_tvalid && m_tready && m_tlast) |=> (state_reg == S_LOAD)))

endmodule

// ----- src/block_schur_matrix_inverse.sv -----
// Each 2x2 division step runs in the serial divider before its result is written.
// Loading takes one element per cycle while no register write is pending; each result
// is fetched from memory before it is shown, and runs do not overlap: a new matrix
// is accepted only after the last result of the previous run has been taken.
// Reset (aresetn low, synchronous): order_log2 returns to 2, loading restarts.
module block_schur_matrix_inverse
    import bsmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel: order_log2
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    // element stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    // inverse stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] inverse_value
    output logic        m_tlast    // last_result
);

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic signed [31:0] result_value;

    // Controller: load count, block program sequencer and result drain
    bsmi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: working memory, multiply-accumulate unit and serial divider
    bsmi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .load_value   ($signed(s_tdata)),
        .sts          (sts),
        .result_value (result_value)
    );

    // Hold the result word until the transaction completes
    assign m_tdata = result_value;

endmodule

// ----- sim/tb.sv -----
module tb;
    import bsmi_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 2000000;

    // Expected inverse element and its last marker.
    typedef struct {
        logic [31:0] value;
        logic        last;
    } inv_elem_t;

    typedef logic signed [31:0] q_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] element_value
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] inverse_value
    logic        m_tlast;    // last_result

    int mismatch_count;
    int cycle_count;
    bit long_run_phase;      // suppress idling on both sides while set

    block_schur_matrix_inverse #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Fixed-point arithmetic of the inverse, Q16.16 with saturation.
    function automatic q_t sat(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return q_t'(v);
    endfunction

    function automatic longint rmul(input q_t x, input q_t y);
        longint p;
        p = longint'(x) * longint'(y) + (64'sd1 <<< (FRAC - 1));
        return p >>> FRAC;   // arithmetic shift is floor
    endfunction

    function automatic q_t rdiv(input longint x, input longint den);
        longint num, q;
        longint unsigned un, ud, uq;
        bit neg;
        num = x * (64'sd1 <<< FRAC);
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        uq = (un + ud / 2) / ud;
        if (uq > (64'd1 << 32)) uq = 64'd1 << 32;
        q = neg ? -longint'(uq) : longint'(uq);
        return sat(q);
    endfunction

    typedef q_t blk2_t[4];

    function automatic blk2_t inv2(input blk2_t a);
        blk2_t y;
        longint det;
        det = rmul(a[0], a[3]) - rmul(a[1], a[2]);
        if (det == 0) begin
            y = '{0, 0, 0, 0};
        end else begin
            y[0] = rdiv(a[3], det);
            y[3] = rdiv(a[0], det);
            y[1] = rdiv(-longint'(a[1]), det);
            y[2] = rdiv(-longint'(a[2]), det);
        end
        return y;
    endfunction

    function automatic blk2_t mm2(input blk2_t a, input blk2_t b);
        blk2_t c;
        for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++)
                c[i*2+k] = sat(rmul(a[i*2], b[k]) + rmul(a[i*2+1], b[2+k]));
        return c;
    endfunction

    class inverse_scoreboard;
        q_t        matrix[16];
        int        fill;
        int        order;
        inv_elem_t pending[$];

        function void set_order(input logic [1:0] lg);
            order = (lg == 2'd2 || lg == 2'd3) ? 4 : 2;
            fill = 0;
        endfunction

        function void push_inverse(input q_t y[16], input int n);
            inv_elem_t e;
            for (int k = 0; k < n * n; k++) begin
                e.value = y[k];
                e.last = (k == n * n - 1);
                pending.push_back(e);
            end
        endfunction

        function void note_element(input logic [31:0] v);
            q_t y[16];
            blk2_t a11, a12, a21, a22, ia, sb, ib, t1, t2;
            bit all_zero;
            if (fill >= order * order) fill = 0;
            matrix[fill++] = v;
            if (fill < order * order) return;
            fill = 0;
            if (order == 2) begin
                blk2_t r;
                r = inv2('{matrix[0], matrix[1], matrix[2], matrix[3]});
                for (int k = 0; k < 4; k++) y[k] = r[k];
                push_inverse(y, 2);
                return;
            end
            all_zero = 1;
            for (int k = 0; k < 16; k++) if (matrix[k] != 0) all_zero = 0;
            for (int k = 0; k < 16; k++) y[k] = 0;
            if (!all_zero) begin
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++) begin
                        a11[i*2+j] = matrix[i*4+j];
                        a12[i*2+j] = matrix[i*4+j+2];
                        a21[i*2+j] = matrix[(i+2)*4+j];
                        a22[i*2+j] = matrix[(i+2)*4+j+2];
                    end
                ia = inv2(a11);
                t2 = mm2(mm2(a21, ia), a12);
                for (int k = 0; k < 4; k++) sb[k] = sat(longint'(a22[k]) - longint'(t2[k]));
                ib = inv2(sb);
                t2 = mm2(mm2(ia, a12), ib);
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        y[i*4+j+2] = sat(-longint'(t2[i*2+j]));
                t1 = mm2(mm2(t2, a21), ia);
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        y[i*4+j] = sat(longint'(ia[i*2+j]) + longint'(t1[i*2+j]));
                t2 = mm2(mm2(ib, a21), ia);
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++) begin
                        y[(i+2)*4+j] = sat(-longint'(t2[i*2+j]));
                        y[(i+2)*4+j+2] = ib[i*2+j];
                    end
            end
            push_inverse(y, 4);
        endfunction

        task check_result(input logic [31:0] value, input logic last);
            inv_elem_t e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", value));
                return;
            end
            e = pending.pop_front();
            if (value !== e.value)
                report_mismatch($sformatf("inverse_value %h, want %h", value, e.value));
            if (last !== e.last)
                report_mismatch($sformatf("last_result %b, want %b", last, e.last));
        endtask
    endclass

    inverse_scoreboard board;

    // Bias random elements toward small Q16.16 values so the inverse stays meaningful.
    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return '0;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            3: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic bit take_gap();
        return !long_run_phase && ($urandom_range(0, 99) < 24);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    task automatic write_order(input logic [1:0] lg);
        wait_drained();
        // let the block settle after the final transaction of the last run
        repeat (50) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= lg;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_order(lg);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_element(input logic [31:0] v);
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_element(v);
        @(negedge aclk);
    endtask

    task automatic send_matrix(input int n, input logic [31:0] m[16]);
        for (int k = 0; k < n * n; k++) send_element(m[k]);
    endtask

    // Sample results at the rising edge; change ready at the falling edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
    end

    always @(negedge aclk) begin
        m_tready <= !aresetn ? 1'b0 : !take_gap();
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] m[16];
        int sent;
        board = new();
        board.set_order(2'd2);
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatch_count = 0;
        cycle_count = 0;
        long_run_phase = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity at reset order, all-zero 4x4, then 2x2 cases.
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
        send_matrix(4, m);
        for (int k = 0; k < 16; k++) m[k] = '0;
        send_matrix(4, m);
        write_order(2'd1);
        // singular block: zero determinant
        send_matrix(2, '{32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000,
                         0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        // extremes: saturation on division and negation
        send_matrix(2, '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h0000_0001,
                         0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        // tiny determinant rounding to zero
        send_matrix(2, '{32'h0000_0001, 0, 0, 32'h0000_0001,
                         0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        write_order(2'd0);   // acts as order 2
        send_matrix(2, '{32'hffff_0000, 32'h0000_8000, 32'h0003_0000, 32'h7fffffff,
                         0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        write_order(2'd3);   // clamped to order 4
        // partial load, then restart by register write
        send_element(32'h1234_5678);
        send_element(32'hdead_beef);
        write_order(2'd2);

        // Random: mostly whole matrices, order changed now and then.
        sent = 0;
        while (sent < 200) begin
            if ($urandom_range(0, 5) == 0) write_order(2'($urandom_range(0, 3)));
            if (sent > 80 && sent < 130) long_run_phase = 1;
            else long_run_phase = 0;
            for (int k = 0; k < board.order * board.order; k++) m[k] = random_element();
            send_matrix(board.order, m);
            sent += board.order * board.order;
            // hold off until the block has drained
            if (sent > 150 && sent < 170) wait_drained();
        end
        long_run_phase = 0;
        wait_drained();
        repeat (1000) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/bsmi_pkg.sv
src/bsmi_datapath.sv
src/bsmi_ctrl.sv
src/block_schur_matrix_inverse.sv
sim/tb.sv
